>>> hdl/rdrs_pkg.sv
// ----------------------------------------------------------------------------
// rdrs_pkg
// Shared types and constants for the relay drive retry supervisor.
// ----------------------------------------------------------------------------
package rdrs_pkg;

    // Number of supervised relay ports (1..8)
    localparam int PORTS = 8;

    // Field widths
    localparam int PORT_W     = 4;
    localparam int MASK_W     = 8;
    localparam int DELAY_W    = 16;
    localparam int TIME_W     = 32;
    localparam int TRIES_W    = 8;
    localparam int INTERVAL_W = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [TRIES_W-1:0]    MAX_RETRIES_RST = TRIES_W'(3);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = INTERVAL_W'(1000);

    // Transaction function codes
    localparam logic FUNC_OPERATE = 1'b0;
    localparam logic FUNC_POLL    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTVL = CFG_IDX_W'(1);

    // Port outcome codes
    typedef enum logic [STATUS_W-1:0] {
        OC_OFF_OK     = 3'd0,
        OC_ON_OK      = 3'd1,
        OC_FAIL_CLOSE = 3'd2,
        OC_STUCK      = 3'd3,
        OC_MISACTION  = 3'd4
    } outcome_t;

    // Per-lane strobes for one transaction
    typedef struct packed {
        logic cmd;   // operate command addressed to this lane
        logic tick;  // poll tick
    } lane_ctl_t;

    // Per-lane result after the transaction
    typedef struct packed {
        logic     drive;
        logic     level;
        logic     busy;
        outcome_t outcome;
    } lane_stat_t;

endpackage

>>> hdl/relay_drive_retry_supervisor_top.sv
// A transaction accepted at one clock edge has its result valid in the
// output register after that edge.
// Throughput: one transaction per cycle while the result side keeps up; all
// PORTS lanes update in parallel in the accept cycle.
// Reset: rst_n asynchronous, active low; clears all port control state and
// loads max_retries = 3 and retry_interval_ms = 1000.
// ----------------------------------------------------------------------------
// relay_drive_retry_supervisor_top
// Relay drive retry supervisor: one lane per port, a merge stage producing
// the result transaction, and the configuration registers.
// ----------------------------------------------------------------------------
module relay_drive_retry_supervisor_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [rdrs_pkg::PORT_W-1:0]     port,
    input  logic                            operate_on,
    input  logic [rdrs_pkg::DELAY_W-1:0]    delay_ms,
    input  logic [rdrs_pkg::MASK_W-1:0]     feedback,
    input  logic [rdrs_pkg::TIME_W-1:0]     now_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rdrs_pkg::MASK_W-1:0]     drive_mask,
    output logic [rdrs_pkg::MASK_W-1:0]     drive_level,
    output logic [rdrs_pkg::MASK_W-1:0]     busy_mask,
    output logic [rdrs_pkg::STATUS_W-1:0]   port_status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rdrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rdrs_pkg::*;

    logic                  in_fire;
    logic [TRIES_W-1:0]    max_retries_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    lane_ctl_t             lane_ctl  [PORTS];
    lane_stat_t            lane_stat [PORTS];

    assign in_ready  = !out_valid || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= MAX_RETRIES_RST;
            interval_reg    <= INTERVAL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[TRIES_W-1:0];
                CFG_RETRY_INTVL: interval_reg    <= cfg_data[INTERVAL_W-1:0];
                default:         ;
            endcase
        end
    end

    // One lane per port
    for (genvar g = 0; g < PORTS; g++)
    begin : g_lane
        assign lane_ctl[g].cmd  = in_fire && (func == FUNC_OPERATE) &&
                                  (port == PORT_W'(g));
        assign lane_ctl[g].tick = in_fire && (func == FUNC_POLL);

        rdrs_lane u_lane
        (
            .clk               (clk),
            .rst_n             (rst_n),
            .ctl               (lane_ctl[g]),
            .operate_on        (operate_on),
            .delay_ms          (delay_ms),
            .fb_bit            (feedback[g]),
            .now_ms            (now_ms),
            .max_retries       (max_retries_reg),
            .retry_interval_ms (interval_reg),
            .stat              (lane_stat[g])
        );
    end

    // Result merge and output register
    rdrs_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .port        (port),
        .lane_stat   (lane_stat),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .drive_mask  (drive_mask),
        .drive_level (drive_level),
        .busy_mask   (busy_mask),
        .port_status (port_status)
    );

endmodule

>>> hdl/rdrs_lane.sv
// ----------------------------------------------------------------------------
// rdrs_lane
// State and update logic of one relay port: command start, delayed drive,
// timed redrive with retry count, final outcome and idle drift checks.
// ----------------------------------------------------------------------------
module rdrs_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdrs_pkg::lane_ctl_t           ctl,
    input  logic                          operate_on,
    input  logic [rdrs_pkg::DELAY_W-1:0]  delay_ms,
    input  logic                          fb_bit,
    input  logic [rdrs_pkg::TIME_W-1:0]   now_ms,
    input  logic [rdrs_pkg::TRIES_W-1:0]  max_retries,
    input  logic [rdrs_pkg::INTERVAL_W-1:0] retry_interval_ms,
    output rdrs_pkg::lane_stat_t          stat
);
    import rdrs_pkg::*;

    logic                busy_reg, busy_next;
    logic                target_reg, target_next;
    logic                sensed_reg, sensed_next;
    outcome_t            outcome_reg, outcome_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [TRIES_W-1:0]  tries_reg, tries_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [TIME_W-1:0]   diff;
    logic                drive;
    logic                level;

    assign diff = now_ms - last_reg;

    // Next-state of the port
    always_comb
    begin
        busy_next    = busy_reg;
        target_next  = target_reg;
        sensed_next  = sensed_reg;
        outcome_next = outcome_reg;
        delay_next   = delay_reg;
        tries_next   = tries_reg;
        last_next    = last_reg;
        drive        = 1'b0;
        level        = 1'b0;

        if (ctl.cmd)
        begin
            // start only on an idle port that is not already at the level
            if (!busy_reg && (sensed_reg != operate_on))
            begin
                busy_next   = 1'b1;
                target_next = operate_on;
                tries_next  = max_retries;
                delay_next  = delay_ms;
                last_next   = now_ms;
                if (delay_ms == '0)
                begin
                    drive = 1'b1;
                    level = operate_on;
                end
            end
        end
        else if (ctl.tick)
        begin
            sensed_next = fb_bit;
            if (busy_reg)
            begin
                if (delay_reg != '0)
                begin
                    // waiting out the initial delay
                    if (diff >= TIME_W'(delay_reg))
                    begin
                        delay_next = '0;
                        last_next  = now_ms;
                        drive      = 1'b1;
                        level      = target_reg;
                    end
                end
                else if (fb_bit == target_reg)
                begin
                    outcome_next = fb_bit ? OC_ON_OK : OC_OFF_OK;
                    busy_next    = 1'b0;
                end
                else if (diff >= TIME_W'(retry_interval_ms))
                begin
                    if (tries_reg != '0)
                    begin
                        tries_next = tries_reg - TRIES_W'(1);
                        last_next  = now_ms;
                        drive      = 1'b1;
                        level      = target_reg;
                    end
                    else
                    begin
                        outcome_next = fb_bit ? OC_FAIL_CLOSE : OC_STUCK;
                        busy_next    = 1'b0;
                    end
                end
            end
            else
            begin
                // idle: drift after success, or recovery from a fault
                if ((outcome_reg == OC_ON_OK) || (outcome_reg == OC_OFF_OK))
                begin
                    if (fb_bit != target_reg)
                        outcome_next = OC_MISACTION;
                end
                else if (fb_bit == target_reg)
                begin
                    outcome_next = fb_bit ? OC_ON_OK : OC_OFF_OK;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            target_reg  <= 1'b0;
            sensed_reg  <= 1'b0;
            outcome_reg <= OC_OFF_OK;
            delay_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            target_reg  <= target_next;
            sensed_reg  <= sensed_next;
            outcome_reg <= outcome_next;
            delay_reg   <= delay_next;
        end
    end

    // Retry count and timestamp, written before first use
    always_ff @(posedge clk)
    begin
        tries_reg <= tries_next;
        last_reg  <= last_next;
    end

    assign stat.drive   = drive;
    assign stat.level   = level;
    assign stat.busy    = busy_next;
    assign stat.outcome = outcome_next;

`ifndef SYNTHESIS
    // a port in its initial delay is always busy
    a_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (delay_reg != '0) |-> busy_reg)
        else $error("delay pending on idle port");

    // a drive strobe only comes with the port busy afterwards
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        drive |-> busy_next)
        else $error("drive strobe on a port left idle");

    // a port leaving busy on a tick, with its final outcome set, is idle afterwards
    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.tick && busy_reg && !busy_next) |=> !busy_reg)
        else $error("port finished but still busy");
`endif

endmodule

>>> hdl/rdrs_merge.sv
// ----------------------------------------------------------------------------
// rdrs_merge
// Combines the lane results into one result transaction and holds it in
// the output register until it is taken.
// ----------------------------------------------------------------------------
module rdrs_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic [rdrs_pkg::PORT_W-1:0]   port,
    input  rdrs_pkg::lane_stat_t          lane_stat [rdrs_pkg::PORTS],
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rdrs_pkg::MASK_W-1:0]   drive_mask,
    output logic [rdrs_pkg::MASK_W-1:0]   drive_level,
    output logic [rdrs_pkg::MASK_W-1:0]   busy_mask,
    output logic [rdrs_pkg::STATUS_W-1:0] port_status
);
    import rdrs_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   drive_mask_reg, drive_mask_next;
    logic [MASK_W-1:0]   drive_level_reg, drive_level_next;
    logic [MASK_W-1:0]   busy_mask_reg, busy_mask_next;
    logic [STATUS_W-1:0] port_status_reg, port_status_next;

    // Gather lane bits and select the addressed port's status (OC_OFF_OK while busy or out of range)
    always_comb
    begin
        drive_mask_next  = '0;
        drive_level_next = '0;
        busy_mask_next   = '0;
        port_status_next = OC_OFF_OK;
        for (int i = 0; i < PORTS; i++)
        begin
            drive_mask_next[i]  = lane_stat[i].drive;
            drive_level_next[i] = lane_stat[i].level;
            busy_mask_next[i]   = lane_stat[i].busy;
            if ((port == PORT_W'(i)) && !lane_stat[i].busy)
                port_status_next = lane_stat[i].outcome;
        end
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            drive_mask_reg  <= drive_mask_next;
            drive_level_reg <= drive_level_next;
            busy_mask_reg   <= busy_mask_next;
            port_status_reg <= port_status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_mask  = drive_mask_reg;
    assign drive_level = drive_level_reg;
    assign busy_mask   = busy_mask_reg;
    assign port_status = port_status_reg;

`ifndef SYNTHESIS
    // levels appear only on strobed ports
    a_level_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((drive_level_reg & ~drive_mask_reg) == '0))
        else $error("drive level set on unstrobed port");

    // status is always a defined outcome
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (port_status_reg <= STATUS_W'(OC_MISACTION)))
        else $error("status code out of range");

    // every accepted transaction produces a result
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted transaction gave no result");
`endif

endmodule

>>> tb/relay_drive_retry_supervisor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_drive_retry_supervisor_top_tb
// Self-checking bench for the relay drive retry supervisor. A behavioral
// copy of the per-port supervision predicts every result transaction. A
// simple relay plant model answers drive strobes on the feedback lines.
// Directed transactions cover commands, status codes, retry exhaustion,
// delays and register extremes. Random traffic runs under varying
// settings and handshake pressure.
// ----------------------------------------------------------------------------
module relay_drive_retry_supervisor_top_tb;

    import rdrs_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);

    typedef struct packed {
        logic [MASK_W-1:0] drive_mask;
        logic [MASK_W-1:0] drive_level;
        logic [MASK_W-1:0] busy_mask;
        outcome_t          status;
    } relay_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = FUNC_OPERATE;
    logic [PORT_W-1:0]     port = '0;
    logic                  operate_on = 1'b0;
    logic [DELAY_W-1:0]    delay_ms = '0;
    logic [MASK_W-1:0]     feedback = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MASK_W-1:0]     drive_mask;
    logic [MASK_W-1:0]     drive_level;
    logic [MASK_W-1:0]     busy_mask;
    logic [STATUS_W-1:0]   port_status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted supervisor state
    logic [TRIES_W-1:0]    retry_budget;
    logic [INTERVAL_W-1:0] redrive_interval;
    logic                  relay_busy    [PORTS];
    logic                  relay_target  [PORTS];
    logic                  relay_sensed  [PORTS];
    outcome_t              relay_outcome [PORTS];
    logic [TRIES_W-1:0]    redrives_left [PORTS];
    logic [DELAY_W-1:0]    hold_off_ms   [PORTS];
    logic [TIME_W-1:0]     last_drive_ms [PORTS];

    relay_report_t         report_q[$];
    logic [MASK_W-1:0]     contact = '0;   // plant: actual relay levels
    logic [TIME_W-1:0]     wall_ms = '0;
    int                    in_gap_pct = 0;
    int                    out_stall_pct = 0;
    int                    error_count = 0;
    int                    quiet_cycles = 0;

    relay_drive_retry_supervisor_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .port        (port),
        .operate_on  (operate_on),
        .delay_ms    (delay_ms),
        .feedback    (feedback),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_mask  (drive_mask),
        .drive_level (drive_level),
        .busy_mask   (busy_mask),
        .port_status (port_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    task automatic flag_error(input string what);
        if (error_count < PRINT_LIMIT)
            $display("%0t ERROR: %s", $time, what);
        error_count++;
    endtask

    function automatic void reset_predictor();
        retry_budget     = MAX_RETRIES_RST;
        redrive_interval = INTERVAL_RST;
        for (int q = 0; q < PORTS; q++)
        begin
            relay_busy[q]    = 1'b0;
            relay_target[q]  = 1'b0;
            relay_sensed[q]  = 1'b0;
            relay_outcome[q] = OC_OFF_OK;
            redrives_left[q] = '0;
            hold_off_ms[q]   = '0;
            last_drive_ms[q] = '0;
        end
    endfunction

    // Apply one transaction to the predicted state and return its result.
    function automatic relay_report_t supervise_relays(
        input logic               fn,
        input logic [PORT_W-1:0]  prt,
        input logic               on,
        input logic [DELAY_W-1:0] dly,
        input logic [MASK_W-1:0]  fb,
        input logic [TIME_W-1:0]  now
    );
        relay_report_t     rep;
        logic [TIME_W-1:0] since;
        int                p;
        rep = '0;
        p = int'(prt);
        if (fn == FUNC_OPERATE)
        begin
            // start an operation only on an idle port that needs to move
            if (p < PORTS)
            begin
                if (!relay_busy[p] && relay_sensed[p] != on)
                begin
                    relay_busy[p]    = 1'b1;
                    relay_target[p]  = on;
                    redrives_left[p] = retry_budget;
                    hold_off_ms[p]   = dly;
                    last_drive_ms[p] = now;
                    if (dly == '0)
                    begin
                        rep.drive_mask[p]  = 1'b1;
                        rep.drive_level[p] = on;
                    end
                end
            end
        end
        else
        begin
            // poll tick: every port in turn
            for (int q = 0; q < PORTS; q++)
            begin
                relay_sensed[q] = fb[q];
                since = now - last_drive_ms[q];
                if (!relay_busy[q])
                begin
                    if (relay_outcome[q] == OC_ON_OK || relay_outcome[q] == OC_OFF_OK)
                    begin
                        if (relay_sensed[q] != relay_target[q])
                            relay_outcome[q] = OC_MISACTION;
                    end
                    else if (relay_sensed[q] == relay_target[q])
                        relay_outcome[q] = relay_sensed[q] ? OC_ON_OK : OC_OFF_OK;
                end
                else if (hold_off_ms[q] != '0)
                begin
                    // waiting out the start delay
                    if (since >= TIME_W'(hold_off_ms[q]))
                    begin
                        hold_off_ms[q]     = '0;
                        last_drive_ms[q]   = now;
                        rep.drive_mask[q]  = 1'b1;
                        rep.drive_level[q] = relay_target[q];
                    end
                end
                else if (relay_sensed[q] == relay_target[q])
                begin
                    relay_outcome[q] = relay_sensed[q] ? OC_ON_OK : OC_OFF_OK;
                    relay_busy[q]    = 1'b0;
                end
                else if (since >= TIME_W'(redrive_interval))
                begin
                    if (redrives_left[q] != '0)
                    begin
                        redrives_left[q]   = redrives_left[q] - TRIES_W'(1);
                        last_drive_ms[q]   = now;
                        rep.drive_mask[q]  = 1'b1;
                        rep.drive_level[q] = relay_target[q];
                    end
                    else
                    begin
                        relay_outcome[q] = relay_sensed[q] ? OC_FAIL_CLOSE : OC_STUCK;
                        relay_busy[q]    = 1'b0;
                    end
                end
            end
        end
        for (int q = 0; q < PORTS; q++)
            rep.busy_mask[q] = relay_busy[q];
        if (p < PORTS)
        begin
            if (!relay_busy[p])
                rep.status = relay_outcome[p];
        end
        return rep;
    endfunction

    // Send one transaction; returns at the edge where it is accepted.
    task automatic send_item(
        input logic               fn,
        input logic [PORT_W-1:0]  prt,
        input logic               on,
        input logic [DELAY_W-1:0] dly,
        input logic [MASK_W-1:0]  fb,
        input logic [TIME_W-1:0]  now
    );
        int            gap;
        relay_report_t rep;
        gap = 0;
        while ($urandom_range(0, 99) < in_gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        port       <= prt;
        operate_on <= on;
        delay_ms   <= dly;
        feedback   <= fb;
        now_ms     <= now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rep = supervise_relays(fn, prt, on, dly, fb, now);
        report_q.push_back(rep);
        // plant: most strobes move the contact, some do not
        for (int q = 0; q < PORTS; q++)
            if (rep.drive_mask[q] && $urandom_range(0, 99) < 75)
                contact[q] = rep.drive_level[q];
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic settle();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MAX_RETRIES: retry_budget = data[TRIES_W-1:0];
            CFG_RETRY_INTVL: redrive_interval = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_gap_pct    = in_pct;
        out_stall_pct = out_pct;
    endtask

    // Commands, ignored commands, status codes, misaction and stuck, reset settings
    task automatic test_operate_and_status();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FE00;   // retry timing crosses the 32-bit wrap
        send_item(FUNC_POLL,    4'd0,  1'b0, 16'd0, 8'h00, t0);
        send_item(FUNC_OPERATE, 4'd0,  1'b1, 16'd0, 8'h00, t0);
        send_item(FUNC_OPERATE, 4'd0,  1'b0, 16'd0, 8'h00, t0);        // busy port
        send_item(FUNC_OPERATE, 4'd1,  1'b0, 16'd0, 8'h00, t0);        // already there
        send_item(FUNC_OPERATE, 4'd15, 1'b1, 16'd0, 8'h00, t0);        // no such port
        send_item(FUNC_POLL,    4'd0,  1'b0, 16'd0, 8'h01, t0 + 5);    // on ok
        send_item(FUNC_POLL,    4'd0,  1'b0, 16'd0, 8'h00, t0 + 10);   // drift
        send_item(FUNC_POLL,    4'd0,  1'b0, 16'd0, 8'h01, t0 + 15);   // back
        send_item(FUNC_OPERATE, 4'd2,  1'b1, 16'd0, 8'h01, t0 + 20);
        send_item(FUNC_POLL,    4'd2,  1'b0, 16'd0, 8'h01, t0 + 1020);
        send_item(FUNC_POLL,    4'd2,  1'b0, 16'd0, 8'h01, t0 + 2020);
        send_item(FUNC_POLL,    4'd2,  1'b0, 16'd0, 8'h01, t0 + 3020);
        send_item(FUNC_POLL,    4'd2,  1'b0, 16'd0, 8'h01, t0 + 4020); // stuck
        send_item(FUNC_POLL,    4'd2,  1'b0, 16'd0, 8'h05, t0 + 4030); // recovered
        send_item(FUNC_POLL,    4'd9,  1'b0, 16'd0, 8'hFF, t0 + 4040);
    endtask

    // No redrives, zero interval: failed close, recovery, stuck
    task automatic test_retry_exhaustion();
        write_register(CFG_MAX_RETRIES, 16'hAB00);   // upper bits unused
        write_register(CFG_RETRY_INTVL, 16'h0000);
        write_register(CFG_SPARE_IDX, 16'hFFFF);
        wall_ms = 32'h0000_1000;
        send_item(FUNC_POLL,    4'd3, 1'b0, 16'd0, 8'h08, wall_ms);
        send_item(FUNC_OPERATE, 4'd3, 1'b0, 16'd0, 8'h08, wall_ms);
        send_item(FUNC_POLL,    4'd3, 1'b0, 16'd0, 8'h08, wall_ms);    // failed close
        send_item(FUNC_POLL,    4'd3, 1'b0, 16'd0, 8'h00, wall_ms + 1);
        send_item(FUNC_OPERATE, 4'd5, 1'b1, 16'd0, 8'h00, wall_ms + 1);
        send_item(FUNC_POLL,    4'd5, 1'b0, 16'd0, 8'h00, wall_ms + 2); // stuck
    endtask

    // Largest settings and the largest start delay at its exact boundary
    task automatic test_delay_and_extremes();
        write_register(CFG_MAX_RETRIES, 16'h00FF);
        write_register(CFG_RETRY_INTVL, 16'hFFFF);
        wall_ms = 32'h7FFF_0000;
        send_item(FUNC_OPERATE, 4'd4, 1'b1, 16'hFFFF, 8'h00, wall_ms);
        send_item(FUNC_POLL,    4'd4, 1'b0, 16'd0, 8'h00, wall_ms + 65534);
        send_item(FUNC_POLL,    4'd4, 1'b0, 16'd0, 8'h00, wall_ms + 65535);
        send_item(FUNC_POLL,    4'd4, 1'b0, 16'd0, 8'h00, wall_ms + 131069);
        send_item(FUNC_POLL,    4'd4, 1'b0, 16'd0, 8'h00, wall_ms + 131070);
        send_item(FUNC_POLL,    4'd4, 1'b0, 16'd0, 8'h10, wall_ms + 131071);
    endtask

    // Plant-driven traffic with some noise, under one register setting
    task automatic test_random_traffic(input logic [TRIES_W-1:0] retries,
                                       input logic [INTERVAL_W-1:0] interval,
                                       input int count);
        int                 roll;
        logic [PORT_W-1:0]  prt;
        logic               on;
        logic [DELAY_W-1:0] dly;
        logic [TIME_W-1:0]  step;
        write_register(CFG_MAX_RETRIES, {8'($urandom), retries});
        write_register(CFG_RETRY_INTVL, interval);
        wall_ms = $urandom;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                prt = PORT_W'($urandom_range(PORTS, 15));
            else
                prt = PORT_W'($urandom_range(0, PORTS - 1));
            if (roll < 3)
            begin
                // noise: every field random, clock jumps
                wall_ms = $urandom;
                send_item(1'($urandom), PORT_W'($urandom), 1'($urandom),
                          DELAY_W'($urandom), MASK_W'($urandom), wall_ms);
            end
            else if (roll < 40)
            begin
                // command, mostly one that moves the relay
                if (int'(prt) < PORTS && $urandom_range(0, 4) != 0)
                    on = ~relay_sensed[int'(prt)];
                else
                    on = 1'($urandom);
                case ($urandom_range(0, 5))
                    0, 1, 2: dly = '0;
                    3, 4:    dly = DELAY_W'($urandom_range(1, 3000));
                    default: dly = DELAY_W'($urandom_range(1, 65535));
                endcase
                send_item(FUNC_OPERATE, prt, on, dly, MASK_W'($urandom), wall_ms);
            end
            else
            begin
                // tick: advance the clock, let contacts drift now and then
                case ($urandom_range(0, 9))
                    0, 1, 2: step = $urandom_range(0, 20);
                    9:       step = $urandom_range(0, 140000);
                    default: step = $urandom_range(0, 32'(interval) + 200);
                endcase
                wall_ms = wall_ms + step;
                for (int q = 0; q < PORTS; q++)
                    if ($urandom_range(0, 49) == 0)
                        contact[q] = ~contact[q];
                send_item(FUNC_POLL, prt, 1'($urandom), DELAY_W'($urandom), contact,
                          wall_ms);
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        relay_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (report_q.size() == 0)
                flag_error("result transaction with nothing expected");
            else
            begin
                want = report_q.pop_front();
                if (drive_mask !== want.drive_mask)
                    flag_error($sformatf("drive_mask %h, expected %h",
                                         drive_mask, want.drive_mask));
                if (drive_level !== want.drive_level)
                    flag_error($sformatf("drive_level %h, expected %h",
                                         drive_level, want.drive_level));
                if (busy_mask !== want.busy_mask)
                    flag_error($sformatf("busy_mask %h, expected %h",
                                         busy_mask, want.busy_mask));
                if (port_status !== want.status)
                    flag_error($sformatf("port_status %0d, expected %0d",
                                         port_status, want.status));
            end
        end
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(30, 83);
        test_operate_and_status();
        test_retry_exhaustion();
        test_delay_and_extremes();
        test_random_traffic(8'd3, 16'd1000, 170);
        test_random_traffic(8'd0, 16'd0, 170);

        set_idling(83, 30);
        test_random_traffic(8'd255, 16'd65535, 170);
        test_random_traffic(TRIES_W'($urandom_range(0, 8)),
                            INTERVAL_W'($urandom_range(1, 3000)), 170);

        set_idling(0, 0);
        test_random_traffic(8'd1, 16'd50, 170);
        test_random_traffic(TRIES_W'($urandom), INTERVAL_W'($urandom), 170);

        settle();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/rdrs_pkg.sv
hdl/rdrs_lane.sv
hdl/rdrs_merge.sv
hdl/relay_drive_retry_supervisor_top.sv
tb/relay_drive_retry_supervisor_top_tb.sv
